FILE: rtl/sorted_set_table_defines.svh
// assertion macros for the sorted set table
// they expect clk and rst_n to be visible where they are used
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_set_table assertion failed");
`define SST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_set_table assertion failed");
`else
`define SST_ASSERT_IMP(lbl, ante, cons)
`define SST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/sst_pkg.sv
package sst_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int DEFAULT_CAPACITY = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_FIND   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } cmd_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] value_out;
        logic [POS_W-1:0]        found_position;
        logic [POS_W-1:0]        entry_count;
    } rsp_t;

    // per-cell load select, at most one bit set
    typedef struct packed {
        logic load_left;
        logic load_key;
        logic load_right;
    } cell_ctrl_t;

    // per-cell compare result against the key
    typedef struct packed {
        logic ge;
        logic eq;
    } cell_flags_t;

endpackage

FILE: rtl/sst_cell.sv
module sst_cell
(
    input  logic                       clk,
    input  sst_pkg::cell_ctrl_t        ctrl,
    input  logic                       occupied,
    input  logic [sst_pkg::VAL_W-1:0]  key,
    input  logic [sst_pkg::VAL_W-1:0]  left_entry,
    input  logic [sst_pkg::VAL_W-1:0]  right_entry,
    output logic [sst_pkg::VAL_W-1:0]  entry,
    output sst_pkg::cell_flags_t       flags
);

    logic [sst_pkg::VAL_W-1:0] entry_reg;
    logic [sst_pkg::VAL_W-1:0] entry_next;

    assign entry = entry_reg;

    // an empty cell counts as greater than any key
    assign flags.ge = !occupied || ($signed(entry_reg) > $signed(key));
    assign flags.eq = occupied && (entry_reg == key);

    always_comb
    begin
        priority if (ctrl.load_left)
        begin
            entry_next = left_entry;
        end
        else if (ctrl.load_key)
        begin
            entry_next = key;
        end
        else if (ctrl.load_right)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/sorted_set_table.sv
// Sorted set table: holds up to CAPACITY distinct signed 32-bit values in
// ascending order in a row of cells. Every operation (insert, remove at
// position, read at position, find value) is a transfer on the cycle where
// start is high; all cells compare against the key in parallel and shift
// toward their neighbor in that same cycle, so one operation is taken every
// clock and its result appears with done in the cycle after the
// transfer. busy is never raised. The receiver cannot stall: results must be
// taken in the cycle that done is high. Reset empties the table at once.
`include "sorted_set_table_defines.svh"

module sorted_set_table
#(
    parameter int CAPACITY = sst_pkg::DEFAULT_CAPACITY
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sst_pkg::cmd_t cmd,
    output logic          done,
    output sst_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > sst_pkg::POS_W) ? CNT_W : sst_pkg::POS_W;

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        done_reg;
    sst_pkg::rsp_t               rsp_reg;
    sst_pkg::rsp_t               rsp_next;

    logic [sst_pkg::VAL_W-1:0]   entry_w [CAPACITY];
    sst_pkg::cell_flags_t        flags_w [CAPACITY];
    sst_pkg::cell_ctrl_t         ctrl_w  [CAPACITY];

    logic [CMP_W-1:0]            pos_ext;
    logic [CMP_W-1:0]            count_ext;
    logic                        pos_ok;
    logic                        dup;
    logic                        full;
    logic                        ins_go;
    logic                        rem_go;
    logic [sst_pkg::VAL_W-1:0]   rd_value;
    logic [sst_pkg::POS_W-1:0]   find_pos;

    assign busy      = 1'b0;
    assign pos_ext   = CMP_W'(cmd.position);
    assign count_ext = CMP_W'(count_reg);
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_ext);
    assign full      = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        dup      = 1'b0;
        rd_value = '0;
        find_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            dup = dup | flags_w[i].eq;
            if (pos_ext == CMP_W'(i + 1))
            begin
                rd_value = rd_value | entry_w[i];
            end
            // values are distinct, so at most one cell matches
            if (flags_w[i].eq)
            begin
                find_pos = find_pos | sst_pkg::POS_W'(i + 1);
            end
        end
    end

    assign ins_go = start && (cmd.operation == sst_pkg::OP_INSERT) && !dup && !full;
    assign rem_go = start && (cmd.operation == sst_pkg::OP_REMOVE) && pos_ok;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic                      occ;
        logic                      at_or_after;
        logic [sst_pkg::VAL_W-1:0] left_src;
        logic [sst_pkg::VAL_W-1:0] right_src;
        logic                      prev_ge;

        assign occ         = (CNT_W'(g) < count_reg);
        assign at_or_after = (CMP_W'(g + 1) >= pos_ext);

        if (g == 0)
        begin : g_first
            assign left_src = entry_w[g];
            assign prev_ge  = 1'b0;
        end
        else
        begin : g_inner
            assign left_src = entry_w[g-1];
            assign prev_ge  = flags_w[g-1].ge;
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_src = entry_w[g];
        end
        else
        begin : g_mid
            assign right_src = entry_w[g+1];
        end

        // insert point is the first cell whose entry is above the key
        assign ctrl_w[g].load_left  = ins_go && flags_w[g].ge && prev_ge;
        assign ctrl_w[g].load_key   = ins_go && flags_w[g].ge && !prev_ge;
        assign ctrl_w[g].load_right = rem_go && at_or_after;

        sst_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl_w[g]),
            .occupied    (occ),
            .key         (cmd.value),
            .left_entry  (left_src),
            .right_entry (right_src),
            .entry       (entry_w[g]),
            .flags       (flags_w[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_go)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rem_go)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next.status         = sst_pkg::ST_OK;
        rsp_next.value_out      = '0;
        rsp_next.found_position = '0;
        rsp_next.entry_count    = sst_pkg::POS_W'(count_next);
        unique case (cmd.operation)
            sst_pkg::OP_INSERT:
            begin
                if (dup)
                begin
                    rsp_next.status = sst_pkg::ST_DUP;
                end
                else if (full)
                begin
                    rsp_next.status = sst_pkg::ST_FULL;
                end
            end
            sst_pkg::OP_REMOVE, sst_pkg::OP_READ:
            begin
                if (pos_ok)
                begin
                    rsp_next.value_out = rd_value;
                end
                else
                begin
                    rsp_next.status = sst_pkg::ST_BADPOS;
                end
            end
            sst_pkg::OP_FIND:
            begin
                rsp_next.found_position = find_pos;
            end
            default:
            begin
                rsp_next.status = sst_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `SST_ASSERT_NEXT(a_done_follows_transfer, start && !busy, done)
    `SST_ASSERT_NEXT(a_count_holds_when_idle, !start, count_reg == $past(count_reg))
    `SST_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SST_ASSERT_IMP(a_full_status_means_full, done && (rsp.status == sst_pkg::ST_FULL), full)

endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int CAPACITY      = DEFAULT_CAPACITY;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_SHOWN     = 10;
    localparam int PHASES        = 7;
    localparam int PHASE_OPS     = 200;

    typedef enum int { MIX_FILL, MIX_BALANCED, MIX_DRAIN } mix_t;

    typedef struct {
        bit   drain;
        cmd_t cmd;
    } op_slot_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    op_slot_t op_queue[$];
    rsp_t     expected_results[$];

    // shadow copy of the table, ascending in slots 0..shadow_count-1
    logic signed [VAL_W-1:0] shadow_vals[CAPACITY];
    int shadow_count = 0;

    logic xfer_last   = 1'b0;
    int   burst_left  = 1;
    int   gap_left    = 0;
    int   total_n     = 0;
    int   accepted_n  = 0;
    int   checked_n   = 0;
    int   fault_n     = 0;
    int   idle_cycles = 0;
    int   find_hits   = 0;
    int   peak_count  = 0;
    int   op_hits[4]     = '{default: 0};
    int   status_hits[4] = '{default: 0};

    logic signed [VAL_W-1:0] value_pool[$];
    logic signed [VAL_W-1:0] seed_vals[16] = '{
        32'sd0, -32'sd2147483648, 32'sd2147483647, -32'sd1, 32'sd1, 32'sd100,
        -32'sd100, 32'sd5, -32'sd5, 32'sh40000000, 32'shC0000000, 32'sd7,
        -32'sd7, 32'sd1000, -32'sd1000, 32'sd2
    };

    sorted_set_table #(.CAPACITY(CAPACITY)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t predict_table_op(cmd_t c);
        rsp_t r;
        int   at;
        bit   dup;
        r   = '0;
        at  = shadow_count;
        dup = 1'b0;
        case (c.operation)
            OP_INSERT:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_vals[i] == c.value)
                    begin
                        dup = 1'b1;
                        break;
                    end
                    if (shadow_vals[i] > c.value)
                    begin
                        at = i;
                        break;
                    end
                end
                if (dup)
                    r.status = ST_DUP;
                else if (shadow_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = shadow_count; i > at; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[at] = c.value;
                    shadow_count++;
                end
            end
            OP_REMOVE, OP_READ:
            begin
                if (c.position == 0 || c.position > shadow_count)
                    r.status = ST_BADPOS;
                else
                begin
                    r.value_out = shadow_vals[c.position-1];
                    if (c.operation == OP_REMOVE)
                    begin
                        for (int i = c.position - 1; i + 1 < shadow_count; i++)
                            shadow_vals[i] = shadow_vals[i+1];
                        shadow_count--;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_vals[i] == c.value)
                    begin
                        r.found_position = POS_W'(i + 1);
                        break;
                    end
                end
            end
        endcase
        r.entry_count = POS_W'(shadow_count);
        return r;
    endfunction

    function automatic void queue_op(logic [1:0] op, logic signed [VAL_W-1:0] v, int pos);
        op_slot_t s;
        s.drain          = 1'b0;
        s.cmd.operation  = op;
        s.cmd.value      = v;
        s.cmd.position   = POS_W'(pos);
        op_queue.push_back(s);
        total_n++;
    endfunction

    function automatic void queue_drain();
        op_slot_t s;
        s.drain = 1'b1;
        s.cmd   = '0;
        op_queue.push_back(s);
    endfunction

    task automatic note_fault(string what);
        fault_n++;
        if (fault_n <= MAX_SHOWN)
            $display("%s", what);
    endtask

    // driver: new items and idle gaps go out on the falling edge
    always @(negedge clk)
    begin : drive
        logic        go;
        cmd_t        next_cmd;
        op_slot_t    s;
        logic [63:0] noise;
        go       = start && !xfer_last;
        next_cmd = cmd;
        noise    = {$urandom, $urandom};
        if (rst_n && !go)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (op_queue.size() != 0)
            begin
                if (op_queue[0].drain)
                begin
                    // hold off until the table has answered everything
                    if (expected_results.size() == 0)
                        s = op_queue.pop_front();
                end
                else
                begin
                    s        = op_queue.pop_front();
                    next_cmd = s.cmd;
                    go       = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 60);
                        if ($urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 9) == 0)
                            gap_left = $urandom_range(8, 20);
                        else
                            gap_left = $urandom_range(1, 5);
                    end
                end
            end
        end
        start <= go;
        if (go)
            cmd <= next_cmd;
        else
            cmd <= noise[$bits(cmd_t)-1:0];
    end

    // transfer tracking, prediction and result checking on the rising edge
    always @(posedge clk)
    begin : sample
        rsp_t want;
        if (!rst_n)
            xfer_last <= 1'b0;
        else
        begin
            xfer_last <= start && !busy;
            if (start && !busy)
            begin
                want = predict_table_op(cmd);
                expected_results.push_back(want);
                accepted_n++;
                op_hits[cmd.operation]++;
                status_hits[want.status]++;
                if (cmd.operation == OP_FIND && want.found_position != 0)
                    find_hits++;
                if (shadow_count > peak_count)
                    peak_count = shadow_count;
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                    note_fault($sformatf({"result with nothing expected: status %0d",
                        " value %0d found %0d count %0d"},
                        rsp.status, rsp.value_out, rsp.found_position, rsp.entry_count));
                else
                begin
                    want = expected_results.pop_front();
                    checked_n++;
                    if (rsp.status !== want.status || rsp.value_out !== want.value_out ||
                        rsp.found_position !== want.found_position ||
                        rsp.entry_count !== want.entry_count)
                        note_fault($sformatf({"result %0d mismatch: expected status %0d",
                            " value %0d found %0d count %0d, got status %0d value %0d",
                            " found %0d count %0d"},
                            checked_n, want.status, want.value_out, want.found_position,
                            want.entry_count, rsp.status, rsp.value_out, rsp.found_position,
                            rsp.entry_count));
                end
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no transfer for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        mix_t                    mix;
        int                      k;
        int                      pos;
        logic [1:0]              op;
        logic signed [VAL_W-1:0] v;

        // empty table
        queue_op(OP_READ, 32'sd0, 1);
        queue_op(OP_REMOVE, 32'sd0, 0);
        queue_op(OP_FIND, 32'sd0, 0);
        // fill out of order, extremes included
        foreach (seed_vals[i])
            queue_op(OP_INSERT, seed_vals[i], 0);
        // duplicate takes priority over full
        queue_op(OP_INSERT, 32'sd2147483647, 0);
        queue_op(OP_INSERT, 32'sd3, 0);
        queue_op(OP_FIND, -32'sd2147483648, 0);
        queue_op(OP_FIND, 32'sd12345, 0);
        queue_op(OP_READ, 32'sd0, 16);
        queue_op(OP_READ, 32'sd0, 0);
        queue_op(OP_REMOVE, 32'sd0, 16);
        queue_op(OP_REMOVE, 32'sd0, 1);
        queue_op(OP_READ, 32'sd0, 15);
        queue_drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            mix = mix_t'(ph % 3);
            value_pool.delete();
            value_pool.push_back(-32'sd2147483648);
            value_pool.push_back(32'sd2147483647);
            value_pool.push_back(32'sd0);
            value_pool.push_back(-32'sd1);
            for (int i = 0; i < 16; i++)
            begin
                if (i % 2 == 0)
                    value_pool.push_back(VAL_W'(int'($urandom_range(0, 400)) - 200));
                else
                    value_pool.push_back($urandom);
            end
            for (int n = 0; n < PHASE_OPS; n++)
            begin
                k = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:     op = (k < 65) ? OP_INSERT : (k < 75) ? OP_REMOVE :
                                       (k < 87) ? OP_READ : OP_FIND;
                    MIX_BALANCED: op = (k < 35) ? OP_INSERT : (k < 60) ? OP_REMOVE :
                                       (k < 80) ? OP_READ : OP_FIND;
                    default:      op = (k < 15) ? OP_INSERT : (k < 65) ? OP_REMOVE :
                                       (k < 80) ? OP_READ : OP_FIND;
                endcase
                k = $urandom_range(0, 99);
                if (k < 65)
                    v = value_pool[$urandom_range(0, value_pool.size() - 1)];
                else if (k < 85)
                    v = $urandom;
                else
                    v = value_pool[$urandom_range(0, value_pool.size() - 1)] +
                        ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
                k = $urandom_range(0, 99);
                if (k < 5)
                    pos = 0;
                else if (k < 15)
                    pos = $urandom_range(0, 16);
                else if (k < 60)
                    pos = $urandom_range(1, 6);
                else
                    pos = $urandom_range(1, 16);
                queue_op(op, v, pos);
            end
            queue_drain();
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (accepted_n != total_n || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("%0d operations (insert %0d, remove %0d, read %0d, find %0d)",
            accepted_n, op_hits[OP_INSERT], op_hits[OP_REMOVE], op_hits[OP_READ],
            op_hits[OP_FIND]);
        $display("%0d results checked; rejects: %0d duplicate, %0d full, %0d bad position",
            checked_n, status_hits[ST_DUP], status_hits[ST_FULL], status_hits[ST_BADPOS]);
        $display("%0d find hits, peak count %0d", find_hits, peak_count);
        if (fault_n == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d checks failed", fault_n);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sorted_set_table.sv
bench/tb_top.sv
